// ===== sv/stk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stk_pkg
// shared sizes, operation and error codes, and sequencer states of the stack
// ----------------------------------------------------------------------------
package stk_pkg;

  localparam int DEPTH   = 128;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int KIND_W  = 3;
  localparam int ERR_W   = 2;
  localparam int COUNT_W = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH        = 3'd0,
    KIND_POP         = 3'd1,
    KIND_PUSH_BOTTOM = 3'd2,
    KIND_REVERSE     = 3'd3,
    KIND_POP_MIDDLE  = 3'd4
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK        = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNDERFLOW = 2'd2
  } err_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHIFT_UP,
    ST_BOTTOM,
    ST_TAKE,
    ST_SHIFT_DOWN,
    ST_REV_LO,
    ST_REV_HI,
    ST_DONE
  } state_t;

endpackage

// ===== sv/stk_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stk_if
// request and response channels of the stack, valid/ready handshake
// ----------------------------------------------------------------------------
interface stk_req_if;
  logic                              valid;
  logic                              ready;
  logic [stk_pkg::KIND_W-1:0]        kind;
  logic signed [stk_pkg::DATA_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface stk_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [stk_pkg::DATA_W-1:0] data;
  logic                              data_valid;
  logic [stk_pkg::ERR_W-1:0]         error;
  logic [stk_pkg::COUNT_W-1:0]       count;
  logic                              is_empty;

  modport source (output valid, output data, output data_valid, output error,
                  output count, output is_empty, input ready);
  modport sink   (input valid, input data, input data_valid, input error,
                  input count, input is_empty, output ready);
endinterface

// ===== sv/stk_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stk_ram
// generic RAM, one write port and two read ports with registered read data
// ----------------------------------------------------------------------------
module stk_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 128,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== sv/stack_with_bottom_insert_reverse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_with_bottom_insert_reverse
// bounded array stack with push, pop, push bottom, reverse and pop middle
// ----------------------------------------------------------------------------
// usage
//   req carries one operation (kind, value); rsp returns exactly one result
//   per request: removed word, its valid flag, error code, new count, empty
//   flag. both channels transfer on valid and ready high at a clock edge.
//   entries live in a two-read, one-write RAM; a small sequencer walks a
//   pointer through it, moving one entry per cycle (a low then a high write per
//   swapped pair for reverse), so every operation runs on that one RAM port set.
// steps per kind, n = count before the op
//   push, refused ops, unknown kinds, push bottom on empty: straight to done
//   pop: the top word is read, then taken
//   push bottom: each of the n entries shifted up, then the new bottom written
//   pop middle: the middle word is taken, then floor(n/2) entries shifted down
//   reverse: floor(n/2) pairs swapped from both ends inward
// throughput: one request at a time; req.ready is high only while idle, and
//   a new request may transfer while the previous response still waits
// reset (rst, synchronous): count goes to zero and no response is pending;
//   RAM contents are not cleared, stale entries above the count are unread
// stall: a finished response waits in the sequencer until the output
//   register frees up; nothing is dropped
// ----------------------------------------------------------------------------
module stack_with_bottom_insert_reverse (
  input logic      clk,
  input logic      rst,
  stk_req_if.sink   req,
  stk_rsp_if.source rsp
);

  import stk_pkg::*;

  state_t state;
  state_t state_next;

  // stored entry count and sequencer pointers
  logic [CNT_W-1:0]  fill;
  logic [ADDR_W-1:0] ptr;   // walking pointer, also low end for reverse
  logic [ADDR_W-1:0] hi;    // high end for reverse

  // result being built
  logic [DATA_W-1:0] val;
  logic [DATA_W-1:0] res_data;
  logic              res_dv;
  err_t              res_err;

  // RAM port signals
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr_a;
  logic [ADDR_W-1:0] ram_raddr_b;
  logic [DATA_W-1:0] ram_rdata_a;
  logic [DATA_W-1:0] ram_rdata_b;

  logic              req_fire;
  logic              rsp_free;
  logic              is_full;
  logic              is_void;
  logic [CNT_W-1:0]  mid_pos;
  logic [CNT_W-1:0]  top_pos;
  logic              down_more;
  logic              rev_more;
  kind_t             req_kind;

  stk_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  assign req_kind  = kind_t'(req.kind);
  assign req_fire  = req.valid && req.ready;
  assign rsp_free  = !rsp.valid || rsp.ready;
  assign is_full   = (fill == CNT_W'(DEPTH));
  assign is_void   = (fill == '0);
  assign top_pos   = fill - CNT_W'(1);
  // skip floor(count/2) entries from the top
  assign mid_pos   = fill - CNT_W'(1) - (fill >> 1);
  // another entry above ptr still has to slide down
  assign down_more = ((CNT_W'(ptr) + CNT_W'(1)) < fill);
  // pointers have not met after this swap
  assign rev_more  = ((CNT_W'(ptr) + CNT_W'(2)) < CNT_W'(hi));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          case (req_kind)
            KIND_PUSH: state_next = ST_DONE;
            KIND_POP, KIND_POP_MIDDLE: begin
              state_next = is_void ? ST_DONE : ST_TAKE;
            end
            KIND_PUSH_BOTTOM: begin
              state_next = (is_full || is_void) ? ST_DONE : ST_SHIFT_UP;
            end
            KIND_REVERSE: begin
              state_next = (fill > CNT_W'(1)) ? ST_REV_LO : ST_DONE;
            end
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_SHIFT_UP:   state_next = (ptr == '0) ? ST_BOTTOM : ST_SHIFT_UP;
      ST_BOTTOM:     state_next = ST_DONE;
      ST_TAKE:       state_next = down_more ? ST_SHIFT_DOWN : ST_DONE;
      ST_SHIFT_DOWN: state_next = down_more ? ST_SHIFT_DOWN : ST_DONE;
      ST_REV_LO:     state_next = ST_REV_HI;
      ST_REV_HI:     state_next = rev_more ? ST_REV_LO : ST_DONE;
      ST_DONE:       state_next = rsp_free ? ST_IDLE : ST_DONE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // RAM control and handshake
  always_comb begin
    req.ready   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr_a = '0;
    ram_raddr_b = '0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req_fire) begin
          case (req_kind)
            KIND_PUSH: begin
              if (!is_full) begin
                ram_we    = 1'b1;
                ram_waddr = fill[ADDR_W-1:0];
                ram_wdata = req.value;
              end
            end
            KIND_POP: begin
              if (!is_void) begin
                ram_re      = 1'b1;
                ram_raddr_a = top_pos[ADDR_W-1:0];
              end
            end
            KIND_POP_MIDDLE: begin
              if (!is_void) begin
                ram_re      = 1'b1;
                ram_raddr_a = mid_pos[ADDR_W-1:0];
              end
            end
            KIND_PUSH_BOTTOM: begin
              if (!is_full && is_void) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = req.value;
              end else if (!is_full) begin
                ram_re      = 1'b1;
                ram_raddr_a = top_pos[ADDR_W-1:0];
              end
            end
            KIND_REVERSE: begin
              if (fill > CNT_W'(1)) begin
                ram_re      = 1'b1;
                ram_raddr_a = '0;
                ram_raddr_b = top_pos[ADDR_W-1:0];
              end
            end
            default: ;
          endcase
        end
      end
      ST_SHIFT_UP: begin
        ram_we    = 1'b1;
        ram_waddr = ptr + ADDR_W'(1);
        ram_wdata = ram_rdata_a;
        if (ptr != '0) begin
          ram_re      = 1'b1;
          ram_raddr_a = ptr - ADDR_W'(1);
        end
      end
      ST_BOTTOM: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = val;
      end
      ST_TAKE: begin
        if (down_more) begin
          ram_re      = 1'b1;
          ram_raddr_a = ptr + ADDR_W'(1);
        end
      end
      ST_SHIFT_DOWN: begin
        ram_we    = 1'b1;
        ram_waddr = ptr - ADDR_W'(1);
        ram_wdata = ram_rdata_a;
        if (down_more) begin
          ram_re      = 1'b1;
          ram_raddr_a = ptr + ADDR_W'(1);
        end
      end
      ST_REV_LO: begin
        ram_we    = 1'b1;
        ram_waddr = ptr;
        ram_wdata = ram_rdata_b;
      end
      ST_REV_HI: begin
        ram_we    = 1'b1;
        ram_waddr = hi;
        ram_wdata = ram_rdata_a;
        if (rev_more) begin
          ram_re      = 1'b1;
          ram_raddr_a = ptr + ADDR_W'(1);
          ram_raddr_b = hi - ADDR_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // a finished response loads, otherwise a transfer empties the register
      if (state == ST_DONE && rsp_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_fire && !is_full &&
              (req_kind == KIND_PUSH || (req_kind == KIND_PUSH_BOTTOM && is_void))) begin
            fill <= fill + CNT_W'(1);
          end
        end
        ST_BOTTOM: fill <= fill + CNT_W'(1);
        ST_TAKE, ST_SHIFT_DOWN: begin
          if (!down_more) begin
            fill <= fill - CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          val      <= req.value;
          res_data <= '0;
          res_dv   <= 1'b0;
          res_err  <= ERR_OK;
          ptr      <= '0;
          hi       <= top_pos[ADDR_W-1:0];
          case (req_kind)
            KIND_PUSH, KIND_PUSH_BOTTOM: begin
              if (is_full) begin
                res_err <= ERR_OVERFLOW;
              end
              ptr <= top_pos[ADDR_W-1:0];
            end
            KIND_POP: begin
              if (is_void) begin
                res_err <= ERR_UNDERFLOW;
              end
              ptr <= top_pos[ADDR_W-1:0];
            end
            KIND_POP_MIDDLE: begin
              if (is_void) begin
                res_err <= ERR_UNDERFLOW;
              end
              ptr <= mid_pos[ADDR_W-1:0];
            end
            default: ;
          endcase
        end
      end
      ST_SHIFT_UP: begin
        if (ptr != '0) begin
          ptr <= ptr - ADDR_W'(1);
        end
      end
      ST_TAKE: begin
        res_data <= ram_rdata_a;
        res_dv   <= 1'b1;
        if (down_more) begin
          ptr <= ptr + ADDR_W'(1);
        end
      end
      ST_SHIFT_DOWN: begin
        if (down_more) begin
          ptr <= ptr + ADDR_W'(1);
        end
      end
      ST_REV_HI: begin
        ptr <= ptr + ADDR_W'(1);
        hi  <= hi - ADDR_W'(1);
      end
      ST_DONE: begin
        if (rsp_free) begin
          rsp.data       <= res_data;
          rsp.data_valid <= res_dv;
          rsp.error      <= res_err;
          rsp.count      <= COUNT_W'(fill);
          rsp.is_empty   <= is_void;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // count never passes capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH))
    else $error("stack count above capacity");

  // a fresh response reports the count held by the sequencer
  a_rsp_count: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> rsp.count == COUNT_W'(fill))
    else $error("response count differs from stored count");

  // an accepted push on a non-full stack grows the count by one
  a_push_grow: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.kind == KIND_PUSH && !is_full
    |=> fill == $past(fill) + CNT_W'(1))
    else $error("push did not grow the stack");

  // no request is taken while a response is still being built
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while busy");
`endif

endmodule

// ===== tb/stack_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_checker
// watches both channels, keeps a shadow stack and checks every response
// ----------------------------------------------------------------------------
module stack_checker (
  input  logic clk,
  input  logic rst,
  stk_req_if   req,
  stk_rsp_if   rsp,
  output int   fail_count,
  output int   pending,
  output int   checked,
  output int   full_refusals,
  output int   empty_refusals,
  output int   spare_ops,
  output int   peak_depth
);
  import stk_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic                     data_valid;
    err_t                     error;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
  } stk_result_t;

  // shadow copy of the stack, entry 0 is the bottom
  logic signed [DATA_W-1:0] words [DEPTH];
  int unsigned              depth_used;
  stk_result_t              expected_q [$];
  stk_result_t              want;

  task automatic flag_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) begin
      $display("%0t ns: mismatch, %s", $time, msg);
    end
  endtask

  function automatic stk_result_t apply_op(input logic [KIND_W-1:0] k,
                                           input logic signed [DATA_W-1:0] v);
    stk_result_t              r;
    int unsigned              i;
    int unsigned              pos;
    logic signed [DATA_W-1:0] held;
    r = '0;
    case (k)
      KIND_PUSH: begin
        if (depth_used >= DEPTH) begin
          r.error = ERR_OVERFLOW;
        end else begin
          words[depth_used] = v;
          depth_used++;
        end
      end
      KIND_POP: begin
        if (depth_used == 0) begin
          r.error = ERR_UNDERFLOW;
        end else begin
          depth_used--;
          r.data       = words[depth_used];
          r.data_valid = 1'b1;
        end
      end
      KIND_PUSH_BOTTOM: begin
        if (depth_used >= DEPTH) begin
          r.error = ERR_OVERFLOW;
        end else begin
          for (i = depth_used; i > 0; i--) words[i] = words[i-1];
          words[0] = v;
          depth_used++;
        end
      end
      KIND_REVERSE: begin
        for (i = 0; i < depth_used / 2; i++) begin
          held                      = words[i];
          words[i]                  = words[depth_used-1-i];
          words[depth_used-1-i]     = held;
        end
      end
      KIND_POP_MIDDLE: begin
        if (depth_used == 0) begin
          r.error = ERR_UNDERFLOW;
        end else begin
          // skip half the entries from the top, take the next one
          pos          = depth_used - 1 - depth_used / 2;
          r.data       = words[pos];
          r.data_valid = 1'b1;
          for (i = pos; i + 1 < depth_used; i++) words[i] = words[i+1];
          depth_used--;
        end
      end
      default: begin
      end
    endcase
    r.count    = COUNT_W'(depth_used);
    r.is_empty = (depth_used == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      depth_used = 0;
      expected_q.delete();
      pending = 0;
    end else begin
      // responses first: a response never belongs to a request of this edge
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          flag_mismatch("response transfer with no request outstanding");
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (rsp.data !== want.data)
            flag_mismatch($sformatf("data got %0d want %0d", rsp.data, want.data));
          if (rsp.data_valid !== want.data_valid)
            flag_mismatch($sformatf("data_valid got %0b want %0b",
                                    rsp.data_valid, want.data_valid));
          if (rsp.error !== want.error)
            flag_mismatch($sformatf("error got %0d want %0d", rsp.error, want.error));
          if (rsp.count !== want.count)
            flag_mismatch($sformatf("count got %0d want %0d", rsp.count, want.count));
          if (rsp.is_empty !== want.is_empty)
            flag_mismatch($sformatf("is_empty got %0b want %0b",
                                    rsp.is_empty, want.is_empty));
        end
      end
      if (req.valid && req.ready) begin
        want = apply_op(req.kind, req.value);
        expected_q.insert(expected_q.size(), want);
        if (want.error == ERR_OVERFLOW) full_refusals++;
        if (want.error == ERR_UNDERFLOW) empty_refusals++;
        if (req.kind > KIND_POP_MIDDLE) spare_ops++;
        if (depth_used > peak_depth) peak_depth = depth_used;
      end
      pending = expected_q.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the stack: directed corner cases, then random
// request streams under three idling mixes, responses checked beside the dut
// ----------------------------------------------------------------------------
module tb_top;
  import stk_pkg::*;

  // kinds above pop middle are spare codes the block must treat as no-ops
  localparam int KIND_SPARE_LO = int'(KIND_POP_MIDDLE) + 1;
  localparam int KIND_SPARE_HI = (1 << KIND_W) - 1;

  localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // rough request count per random phase
  localparam int PHASE_ITEMS = 130;

  typedef enum int {TREND_MIX, TREND_RISE, TREND_FALL} trend_t;

  logic clk = 1'b0;
  logic rst;

  // percent of cycles in which each side holds off
  int tx_idle_pct;
  int rx_idle_pct;
  int sent;

  int fail_count;
  int pending;
  int checked;
  int full_refusals;
  int empty_refusals;
  int spare_ops;
  int peak_depth;

  stk_req_if req_ch ();
  stk_rsp_if rsp_ch ();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  stack_with_bottom_insert_reverse dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  stack_checker chk (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .fail_count     (fail_count),
    .pending        (pending),
    .checked        (checked),
    .full_refusals  (full_refusals),
    .empty_refusals (empty_refusals),
    .spare_ops      (spare_ops),
    .peak_depth     (peak_depth)
  );

  // response side: ready drops at random, per cycle
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // one request transfer; valid stays high afterwards so back-to-back
  // requests need no extra nonblocking write in the same step
  task automatic send_request(input logic [KIND_W-1:0] k,
                              input logic signed [DATA_W-1:0] v);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind  <= k;
    req_ch.value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
  endtask

  // hold off requests until every outstanding response has come back
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 19))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // operation mix leans toward growing or shrinking the stack per trend
  function automatic logic [KIND_W-1:0] pick_kind(input trend_t trend);
    int roll;
    int t_push;
    int t_bottom;
    int t_pop;
    int t_mid;
    roll = $urandom_range(0, 99);
    if (roll < 4) return KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    case (trend)
      TREND_RISE: begin
        t_push = 50; t_bottom = 78; t_pop = 86; t_mid = 93;
      end
      TREND_FALL: begin
        t_push = 12; t_bottom = 22; t_pop = 55; t_mid = 88;
      end
      default: begin
        t_push = 30; t_bottom = 50; t_pop = 70; t_mid = 88;
      end
    endcase
    if (roll < t_push)   return KIND_PUSH;
    if (roll < t_bottom) return KIND_PUSH_BOTTOM;
    if (roll < t_pop)    return KIND_POP;
    if (roll < t_mid)    return KIND_POP_MIDDLE;
    return KIND_REVERSE;
  endfunction

  // hard cap on run time
  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int     tx_by_phase [3];
    int     rx_by_phase [3];
    int     phase;
    int     phase_items;
    int     run_len;
    bit     climbed;
    trend_t trend;

    tx_by_phase = '{21, 55, 0};
    rx_by_phase = '{55, 21, 0};
    climbed     = 1'b0;
    tx_idle_pct = tx_by_phase[0];
    rx_idle_pct = rx_by_phase[0];

    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.kind  <= KIND_PUSH;
    req_ch.value <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed corners: refusals on empty, no-op kinds, single-entry
    // reverse, middle removal at small depths, extreme and alternating words
    send_request(KIND_POP, '0);
    send_request(KIND_POP_MIDDLE, '0);
    send_request(KIND_REVERSE, '0);
    send_request(KIND_W'(KIND_SPARE_LO), WORD_MAX);
    send_request(KIND_PUSH, WORD_MAX);
    send_request(KIND_REVERSE, '0);
    send_request(KIND_POP_MIDDLE, '0);
    send_request(KIND_PUSH, WORD_MIN);
    send_request(KIND_PUSH_BOTTOM, '1);
    send_request(KIND_PUSH, '0);
    send_request(KIND_PUSH_BOTTOM, WORD_MAX);
    send_request(KIND_REVERSE, '0);
    send_request(KIND_POP_MIDDLE, '0);
    send_request(KIND_W'(KIND_SPARE_LO + 1), '1);
    send_request(KIND_W'(KIND_SPARE_HI), WORD_MIN);
    send_request(KIND_PUSH, 32'h5555_5555);
    send_request(KIND_PUSH_BOTTOM, 32'hAAAA_AAAA);
    send_request(KIND_REVERSE, '0);
    send_request(KIND_POP, '0);
    send_request(KIND_POP_MIDDLE, '0);
    send_request(KIND_POP, '0);
    send_request(KIND_POP, '0);
    send_request(KIND_POP, '0);
    send_request(KIND_POP, '0);

    // random part, one idling mix per phase; each phase ends with a full
    // drain so the sender stalls until the response side has caught up
    for (phase = 0; phase < 3; phase++) begin
      tx_idle_pct = tx_by_phase[phase];
      rx_idle_pct = rx_by_phase[phase];
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if (phase == 1 && !climbed) begin
          // push until full and past it, then long moves on a full stack
          climbed = 1'b1;
          repeat (DEPTH + 4) begin
            send_request($urandom_range(0, 1) ? KIND_PUSH : KIND_PUSH_BOTTOM,
                         pick_word());
          end
          send_request(KIND_REVERSE, '0);
          send_request(KIND_POP_MIDDLE, '0);
          send_request(KIND_PUSH_BOTTOM, pick_word());
          send_request(KIND_PUSH, pick_word());
          send_request(KIND_POP_MIDDLE, '0);
          phase_items += DEPTH + 9;
        end else begin
          trend   = trend_t'($urandom_range(0, 2));
          run_len = $urandom_range(10, 40);
          repeat (run_len) send_request(pick_kind(trend), pick_word());
          phase_items += run_len;
        end
      end
      drain_responses();
    end

    // every response is in; give the block a little longer to misbehave
    wait (pending == 0);
    repeat (4 * DEPTH) @(posedge clk);

    $display("run covered %0d requests and %0d checked responses, peak depth %0d of %0d",
             sent, checked, peak_depth, DEPTH);
    $display("refused on full %0d, refused on empty %0d, spare kinds %0d",
             full_refusals, empty_refusals, spare_ops);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
